>>> sv/gbs_pkg.sv
// Shared types, widths and sequencer codes for the gravity body step block.
package gbs_pkg;

    // Default table depth.
    localparam int MAX_BODIES_DEF = 16;

    // Field widths.
    localparam int POS_W  = 28;
    localparam int VEL_W  = 32;
    localparam int MASS_W = 8;
    localparam int DT_W   = 16;
    localparam int PIX_W  = 12;
    localparam int IDX_W  = 6;
    localparam int LIM_W  = 13;
    localparam int G_W    = 16;
    localparam int MIND_W = 16;

    // Internal arithmetic widths.
    localparam int D2_W   = 57;
    localparam int ROOT_W = 29;
    localparam int NUM_W  = 56;
    localparam int DEN_W  = 34;
    localparam int F_W    = 56;
    localparam int M_W    = 48;
    localparam int U_W    = 17;

    // 0.7 in Q0.16.
    localparam logic [15:0] SEVEN_TENTHS = 16'd45875;

    // Configuration register set.
    typedef struct packed {
        logic [LIM_W-1:0]  screen_width;
        logic [LIM_W-1:0]  screen_height;
        logic [G_W-1:0]    gravity_strength;
        logic [MIND_W-1:0] min_distance_squared;
    } cfg_t;

    // One table entry.
    typedef struct packed {
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [VEL_W-1:0]  vx;
        logic [VEL_W-1:0]  vy;
        logic [MASS_W-1:0] w;
    } body_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic [5:0] op;
        logic       load;
        logic       step_go;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sqrt_busy;
        logic div_busy;
    } stat_t;

    // Sequencer steps; the controller state and the datapath operation share these codes.
    localparam logic [5:0] ST_IDLE = 6'd0;
    localparam logic [5:0] ST_RDI  = 6'd1;
    localparam logic [5:0] ST_LATI = 6'd2;
    localparam logic [5:0] ST_GM   = 6'd3;
    localparam logic [5:0] ST_CHK  = 6'd4;
    localparam logic [5:0] ST_LATJ = 6'd5;
    localparam logic [5:0] ST_MXX  = 6'd6;
    localparam logic [5:0] ST_MYY  = 6'd7;
    localparam logic [5:0] ST_SUM  = 6'd8;
    localparam logic [5:0] ST_SQS  = 6'd9;
    localparam logic [5:0] ST_SQW  = 6'd10;
    localparam logic [5:0] ST_DVX  = 6'd11;
    localparam logic [5:0] ST_DWX  = 6'd12;
    localparam logic [5:0] ST_DVY  = 6'd13;
    localparam logic [5:0] ST_DWY  = 6'd14;
    localparam logic [5:0] ST_DVM  = 6'd15;
    localparam logic [5:0] ST_DWM  = 6'd16;
    localparam logic [5:0] ST_FX0  = 6'd17;
    localparam logic [5:0] ST_FX1  = 6'd18;
    localparam logic [5:0] ST_FX2  = 6'd19;
    localparam logic [5:0] ST_FX3  = 6'd20;
    localparam logic [5:0] ST_FY0  = 6'd21;
    localparam logic [5:0] ST_FY1  = 6'd22;
    localparam logic [5:0] ST_FY2  = 6'd23;
    localparam logic [5:0] ST_FY3  = 6'd24;
    localparam logic [5:0] ST_BDX  = 6'd25;
    localparam logic [5:0] ST_BWX  = 6'd26;
    localparam logic [5:0] ST_VX0  = 6'd27;
    localparam logic [5:0] ST_VX1  = 6'd28;
    localparam logic [5:0] ST_VX2  = 6'd29;
    localparam logic [5:0] ST_VX3  = 6'd30;
    localparam logic [5:0] ST_VX4  = 6'd31;
    localparam logic [5:0] ST_BDY  = 6'd32;
    localparam logic [5:0] ST_BWY  = 6'd33;
    localparam logic [5:0] ST_VY0  = 6'd34;
    localparam logic [5:0] ST_VY1  = 6'd35;
    localparam logic [5:0] ST_VY2  = 6'd36;
    localparam logic [5:0] ST_VY3  = 6'd37;
    localparam logic [5:0] ST_VY4  = 6'd38;
    localparam logic [5:0] ST_MX0  = 6'd39;
    localparam logic [5:0] ST_MX1  = 6'd40;
    localparam logic [5:0] ST_MY0  = 6'd41;
    localparam logic [5:0] ST_MY1  = 6'd42;
    localparam logic [5:0] ST_WB   = 6'd43;

endpackage

>>> sv/gbs_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module gbs_sqrt
    import gbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [D2_W-1:0]   radicand,
    output logic              busy,
    output logic [ROOT_W-1:0] root
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;

    logic [ROOT_W+3:0] shifted;
    logic [ROOT_W+3:0] trial;
    logic              fits;

    // Bring in the next two radicand bits and try the next root bit.
    always_comb
    begin
        shifted = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        fits    = (shifted >= trial);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(ROOT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= RAD_W'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= (ROOT_W+2)'(shifted - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted[ROOT_W+1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

>>> sv/gbs_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module gbs_div
    import gbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [DEN_W:0]   shifted;
    logic             fits;

    // Shift in the next dividend bit and compare with the divisor.
    always_comb
    begin
        shifted = {rem_reg, num_reg[NUM_W-1]};
        fits    = (shifted >= {1'b0, den_reg});
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // The dividend register fills with quotient bits from the bottom.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= DEN_W'(shifted - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= shifted[DEN_W-1:0];
            end
            num_reg <= {num_reg[NUM_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quo  = num_reg;

endmodule

>>> sv/gbs_datapath.sv
// Datapath: body table, force accumulation, velocity update and bounded move.
module gbs_datapath
    import gbs_pkg::*;
#(
    parameter int MAX_BODIES = MAX_BODIES_DEF,
    parameter int IW = $clog2(MAX_BODIES)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  logic [IW-1:0]      addr,
    input  cfg_t               cfg,
    input  logic [POS_W-1:0]   pos_x,
    input  logic [POS_W-1:0]   pos_y,
    input  logic [VEL_W-1:0]   vel_x,
    input  logic [VEL_W-1:0]   vel_y,
    input  logic [MASS_W-1:0]  body_mass,
    input  logic [DT_W-1:0]    time_step,
    output stat_t              stat,
    output logic [PIX_W-1:0]   pixel_x,
    output logic [PIX_W-1:0]   pixel_y
);

    // Body table.
    body_t mem [MAX_BODIES];
    body_t rd_q;
    body_t wr_data;
    logic  we;

    // Per body and per pair registers.
    logic [POS_W-1:0]         xi_reg, yi_reg;
    logic signed [VEL_W-1:0]  vxi_reg, vyi_reg;
    logic [MASS_W-1:0]        wi_reg, mj_reg;
    logic [DT_W-1:0]          dt_reg;
    logic [31:0]              sp_reg;
    logic [15:0]              s_reg;
    logic [23:0]              gm_reg;
    logic [31:0]              k_reg;
    logic [POS_W-1:0]         ax_reg, ay_reg;
    logic                     sx_reg, sy_reg;
    logic [55:0]              sq1_reg, sq2_reg;
    logic [D2_W-1:0]          d2_reg;
    logic [ROOT_W-1:0]        d_reg;
    logic [U_W-1:0]           ux_reg, uy_reg;
    logic [M_W-1:0]           m_reg;
    logic [40:0]              pl_reg, ph_reg;
    logic [64:0]              t_reg;
    logic signed [F_W-1:0]    fx_reg, fy_reg;
    logic [NUM_W-1:0]         axm_reg;
    logic [39:0]              q0_reg;
    logic [31:0]              q1_reg, q2_reg;
    logic [56:0]              dv_reg;
    logic [47:0]              dmp_reg;
    logic [PIX_W-1:0]         pixel_x_reg, pixel_y_reg;

    // Shared unit connections.
    logic               sqrt_start, sqrt_busy;
    logic [ROOT_W-1:0]  sqrt_root;
    logic               div_start, div_busy;
    logic [NUM_W-1:0]   div_num, div_quo;
    logic [DEN_W-1:0]   div_den;

    // Combinational helpers.
    logic signed [POS_W:0]  dx_s, dy_s;
    logic [D2_W-1:0]        d2_sum, d2_min;
    logic [MIND_W-1:0]      mind_eff;
    logic                   pass_y;
    logic [U_W-1:0]         u_sel;
    logic                   s_neg;
    logic signed [F_W-1:0]  f_sel;
    logic signed [VEL_W-1:0] v_sel;
    logic signed [57:0]     v_sum;
    logic                   axis_y;
    logic [POS_W-1:0]       m_pos;
    logic signed [VEL_W-1:0] m_vel;
    logic [LIM_W-1:0]       m_lim;
    logic [VEL_W-1:0]       v_mag;
    logic signed [34:0]     np_s, lim_s;
    logic signed [LIM_W:0]  lim_px;
    logic                   bounce;
    logic [28:0]            px_sum, py_sum;

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [57:0] v);
        logic signed [VEL_W-1:0] r;
        if (v > 58'sd2147483647)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -58'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[VEL_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [VEL_W-1:0] neg_vel(input logic signed [VEL_W-1:0] v);
        logic signed [VEL_W-1:0] r;
        if (v == 32'sh8000_0000)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else
        begin
            r = -v;
        end
        return r;
    endfunction

    function automatic logic [NUM_W-1:0] f_mag(input logic signed [F_W-1:0] f);
        logic [NUM_W-1:0] r;
        if (f[F_W-1])
        begin
            r = NUM_W'(-f);
        end
        else
        begin
            r = NUM_W'(f);
        end
        return r;
    endfunction

    gbs_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (d2_reg),
        .busy     (sqrt_busy),
        .root     (sqrt_root)
    );

    gbs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    assign stat.sqrt_busy = sqrt_busy;
    assign stat.div_busy  = div_busy;

    // Table write data: a new body on load, the updated body on write back.
    always_comb
    begin
        we = cmd.load || (cmd.op == ST_WB);
        if (cmd.load)
        begin
            wr_data.x  = pos_x;
            wr_data.y  = pos_y;
            wr_data.vx = vel_x;
            wr_data.vy = vel_y;
            wr_data.w  = (body_mass == '0) ? MASS_W'(1) : body_mass;
        end
        else
        begin
            wr_data.x  = xi_reg;
            wr_data.y  = yi_reg;
            wr_data.vx = vxi_reg;
            wr_data.vy = vyi_reg;
            wr_data.w  = wi_reg;
        end
    end

    // Table with registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wr_data;
        end
        rd_q <= mem[addr];
    end

    // Distance terms of the pair.
    always_comb
    begin
        dx_s     = $signed({1'b0, rd_q.x}) - $signed({1'b0, xi_reg});
        dy_s     = $signed({1'b0, rd_q.y}) - $signed({1'b0, yi_reg});
        mind_eff = (cfg.min_distance_squared == '0) ? MIND_W'(1) : cfg.min_distance_squared;
        d2_sum   = D2_W'(sq1_reg) + D2_W'(sq2_reg);
        d2_min   = D2_W'({mind_eff, 32'd0});
    end

    // Divider operand selection.
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (cmd.op)
            ST_DVX:
            begin
                div_start = 1'b1;
                div_num   = NUM_W'({ax_reg, 16'd0});
                div_den   = DEN_W'(d_reg);
            end
            ST_DVY:
            begin
                div_start = 1'b1;
                div_num   = NUM_W'({ay_reg, 16'd0});
                div_den   = DEN_W'(d_reg);
            end
            ST_DVM:
            begin
                div_start = 1'b1;
                div_num   = NUM_W'({k_reg, 24'd0});
                div_den   = DEN_W'(d2_reg[D2_W-1:24]);
            end
            ST_BDX:
            begin
                div_start = 1'b1;
                div_num   = f_mag(fx_reg);
                div_den   = DEN_W'(wi_reg);
            end
            ST_BDY:
            begin
                div_start = 1'b1;
                div_num   = f_mag(fy_reg);
                div_den   = DEN_W'(wi_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
        sqrt_start = (cmd.op == ST_SQS);
    end

    // Axis selection for the force, velocity and move passes.
    always_comb
    begin
        pass_y = (cmd.op == ST_FY0) || (cmd.op == ST_FY1) || (cmd.op == ST_FY2)
              || (cmd.op == ST_FY3) || (cmd.op == ST_VY4);
        u_sel  = pass_y ? uy_reg : ux_reg;
        s_neg  = pass_y ? sy_reg : sx_reg;
        f_sel  = pass_y ? fy_reg : fx_reg;
        v_sel  = pass_y ? vyi_reg : vxi_reg;
        if (f_sel[F_W-1])
        begin
            v_sum = {{26{v_sel[VEL_W-1]}}, v_sel} - $signed({1'b0, dv_reg});
        end
        else
        begin
            v_sum = {{26{v_sel[VEL_W-1]}}, v_sel} + $signed({1'b0, dv_reg});
        end

        axis_y = (cmd.op == ST_MY0) || (cmd.op == ST_MY1);
        m_pos  = axis_y ? yi_reg : xi_reg;
        m_vel  = axis_y ? vyi_reg : vxi_reg;
        m_lim  = axis_y ? cfg.screen_height : cfg.screen_width;
        v_mag  = m_vel[VEL_W-1] ? (~m_vel + 1'b1) : m_vel;
        if (m_vel[VEL_W-1])
        begin
            np_s = $signed({7'd0, m_pos}) - $signed({3'd0, dmp_reg[47:16]});
        end
        else
        begin
            np_s = $signed({7'd0, m_pos}) + $signed({3'd0, dmp_reg[47:16]});
        end
        lim_px = $signed({1'b0, m_lim}) - 14'sd1;
        lim_s  = {{5{lim_px[LIM_W]}}, lim_px, 16'd0};
        bounce = np_s[34] || (np_s >= lim_s) || (np_s > 35'sh0FFF_FFFF);

        px_sum = {1'b0, xi_reg} + 29'd32768;
        py_sum = {1'b0, yi_reg} + 29'd32768;
    end

    // Sequenced register updates.
    always_ff @(posedge clk)
    begin
        if (cmd.step_go)
        begin
            sp_reg <= 32'(time_step) * 32'(SEVEN_TENTHS);
            dt_reg <= time_step;
        end
        unique case (cmd.op)
            ST_RDI:
            begin
                s_reg <= 16'((33'(sp_reg) + 33'd32768) >> 16);
            end
            ST_LATI:
            begin
                xi_reg  <= rd_q.x;
                yi_reg  <= rd_q.y;
                vxi_reg <= rd_q.vx;
                vyi_reg <= rd_q.vy;
                wi_reg  <= rd_q.w;
            end
            ST_GM:
            begin
                gm_reg <= 24'(cfg.gravity_strength) * 24'(wi_reg);
                fx_reg <= '0;
                fy_reg <= '0;
            end
            ST_LATJ:
            begin
                sx_reg <= dx_s[POS_W];
                sy_reg <= dy_s[POS_W];
                ax_reg <= dx_s[POS_W] ? POS_W'(-dx_s) : dx_s[POS_W-1:0];
                ay_reg <= dy_s[POS_W] ? POS_W'(-dy_s) : dy_s[POS_W-1:0];
                mj_reg <= rd_q.w;
            end
            ST_MXX:
            begin
                sq1_reg <= 56'(ax_reg) * 56'(ax_reg);
                k_reg   <= 32'(gm_reg) * 32'(mj_reg);
            end
            ST_MYY:
            begin
                sq2_reg <= 56'(ay_reg) * 56'(ay_reg);
            end
            ST_SUM:
            begin
                d2_reg <= (d2_sum < d2_min) ? d2_min : d2_sum;
            end
            ST_SQW:
            begin
                if (!sqrt_busy)
                begin
                    d_reg <= sqrt_root;
                end
            end
            ST_DWX:
            begin
                if (!div_busy)
                begin
                    ux_reg <= div_quo[U_W-1:0];
                end
            end
            ST_DWY:
            begin
                if (!div_busy)
                begin
                    uy_reg <= div_quo[U_W-1:0];
                end
            end
            ST_DWM:
            begin
                if (!div_busy)
                begin
                    m_reg <= div_quo[M_W-1:0];
                end
            end
            ST_FX0, ST_FY0:
            begin
                pl_reg <= 41'(m_reg[23:0]) * 41'(u_sel);
            end
            ST_FX1, ST_FY1:
            begin
                ph_reg <= 41'(m_reg[47:24]) * 41'(u_sel);
            end
            ST_FX2, ST_FY2:
            begin
                t_reg <= {ph_reg, 24'd0} + 65'(pl_reg);
            end
            ST_FX3:
            begin
                if (s_neg)
                begin
                    fx_reg <= fx_reg - $signed(F_W'(t_reg[64:16]));
                end
                else
                begin
                    fx_reg <= fx_reg + $signed(F_W'(t_reg[64:16]));
                end
            end
            ST_FY3:
            begin
                if (s_neg)
                begin
                    fy_reg <= fy_reg - $signed(F_W'(t_reg[64:16]));
                end
                else
                begin
                    fy_reg <= fy_reg + $signed(F_W'(t_reg[64:16]));
                end
            end
            ST_BWX, ST_BWY:
            begin
                if (!div_busy)
                begin
                    axm_reg <= div_quo;
                end
            end
            ST_VX0, ST_VY0:
            begin
                q0_reg <= 40'(axm_reg[55:32]) * 40'(s_reg);
            end
            ST_VX1, ST_VY1:
            begin
                q1_reg <= 32'(axm_reg[31:16]) * 32'(s_reg);
            end
            ST_VX2, ST_VY2:
            begin
                q2_reg <= 32'(axm_reg[15:0]) * 32'(s_reg);
            end
            ST_VX3, ST_VY3:
            begin
                dv_reg <= 57'({q0_reg, 16'd0}) + 57'(q1_reg) + 57'(q2_reg[31:16]);
            end
            ST_VX4:
            begin
                vxi_reg <= sat_vel(v_sum);
            end
            ST_VY4:
            begin
                vyi_reg <= sat_vel(v_sum);
            end
            ST_MX0, ST_MY0:
            begin
                dmp_reg <= 48'(v_mag) * 48'(dt_reg);
            end
            ST_MX1:
            begin
                if (bounce)
                begin
                    vxi_reg <= neg_vel(vxi_reg);
                end
                else
                begin
                    xi_reg <= np_s[POS_W-1:0];
                end
            end
            ST_MY1:
            begin
                if (bounce)
                begin
                    vyi_reg <= neg_vel(vyi_reg);
                end
                else
                begin
                    yi_reg <= np_s[POS_W-1:0];
                end
            end
            ST_WB:
            begin
                pixel_x_reg <= px_sum[27:16];
                pixel_y_reg <= py_sum[27:16];
            end
            default:
            begin
            end
        endcase
    end

    assign pixel_x = pixel_x_reg;
    assign pixel_y = pixel_y_reg;

endmodule

>>> sv/gbs_ctrl.sv
// Controller: sequences loads, the pair loop and the per body update.
module gbs_ctrl
    import gbs_pkg::*;
#(
    parameter int MAX_BODIES = MAX_BODIES_DEF,
    parameter int IW = $clog2(MAX_BODIES)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             operation,
    input  stat_t            stat,
    output cmd_t             cmd,
    output logic [IW-1:0]    addr,
    output logic             busy,
    output logic             done,
    output logic [IDX_W-1:0] body_index,
    output logic             last_body
);

    localparam int CW = $clog2(MAX_BODIES + 1);

    logic [5:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [IW-1:0]    i_reg, i_next;
    logic [CW-1:0]    j_reg, j_next;
    logic             done_reg, done_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic             last_reg, last_next;
    logic             accept;
    logic             is_last;

    assign accept  = start && (state_reg == ST_IDLE);
    assign is_last = ((CW'(i_reg) + 1'b1) == count_reg);

    // Next state and command.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        done_next   = 1'b0;
        idx_next    = idx_reg;
        last_next   = last_reg;
        cmd.op      = state_reg;
        cmd.load    = 1'b0;
        cmd.step_go = 1'b0;
        addr        = i_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                addr = count_reg[IW-1:0];
                if (accept && !operation && (count_reg < CW'(MAX_BODIES)))
                begin
                    cmd.load   = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                if (accept && operation)
                begin
                    cmd.step_go = 1'b1;
                    i_next      = '0;
                    if (count_reg != '0)
                    begin
                        state_next = ST_RDI;
                    end
                end
            end
            ST_RDI:  state_next = ST_LATI;
            ST_LATI: state_next = ST_GM;
            ST_GM:
            begin
                j_next     = '0;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                addr = j_reg[IW-1:0];
                if (j_reg == count_reg)
                begin
                    state_next = ST_BDX;
                end
                else if (j_reg == CW'(i_reg))
                begin
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_LATJ;
                end
            end
            ST_LATJ: state_next = ST_MXX;
            ST_MXX:  state_next = ST_MYY;
            ST_MYY:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_SQS;
            ST_SQS:  state_next = ST_SQW;
            ST_SQW:
            begin
                if (!stat.sqrt_busy)
                begin
                    state_next = ST_DVX;
                end
            end
            ST_DVX:  state_next = ST_DWX;
            ST_DWX:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_DVY;
                end
            end
            ST_DVY:  state_next = ST_DWY;
            ST_DWY:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_DVM;
                end
            end
            ST_DVM:  state_next = ST_DWM;
            ST_DWM:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_FX0;
                end
            end
            ST_FX0:  state_next = ST_FX1;
            ST_FX1:  state_next = ST_FX2;
            ST_FX2:  state_next = ST_FX3;
            ST_FX3:  state_next = ST_FY0;
            ST_FY0:  state_next = ST_FY1;
            ST_FY1:  state_next = ST_FY2;
            ST_FY2:  state_next = ST_FY3;
            ST_FY3:
            begin
                j_next     = j_reg + 1'b1;
                state_next = ST_CHK;
            end
            ST_BDX:  state_next = ST_BWX;
            ST_BWX:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_VX0;
                end
            end
            ST_VX0:  state_next = ST_VX1;
            ST_VX1:  state_next = ST_VX2;
            ST_VX2:  state_next = ST_VX3;
            ST_VX3:  state_next = ST_VX4;
            ST_VX4:  state_next = ST_BDY;
            ST_BDY:  state_next = ST_BWY;
            ST_BWY:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_VY0;
                end
            end
            ST_VY0:  state_next = ST_VY1;
            ST_VY1:  state_next = ST_VY2;
            ST_VY2:  state_next = ST_VY3;
            ST_VY3:  state_next = ST_VY4;
            ST_VY4:  state_next = ST_MX0;
            ST_MX0:  state_next = ST_MX1;
            ST_MX1:  state_next = ST_MY0;
            ST_MY0:  state_next = ST_MY1;
            ST_MY1:  state_next = ST_WB;
            ST_WB:
            begin
                done_next = 1'b1;
                idx_next  = i_reg;
                last_next = is_last;
                if (is_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_RDI;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            done_reg  <= done_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign body_index = IDX_W'(idx_reg);
    assign last_body  = last_reg;

endmodule

>>> sv/gravity_body_step.sv
// Top level of the direct-sum gravity body step block.
//
// Commands enter on start while busy is low. A load command (operation 0)
// appends one body in the same cycle and busy stays low; a load into a full
// table is dropped. A step command (operation 1) raises busy and updates every
// body in table order; each body's result (body_index, pixel_x, pixel_y and
// last_body) appears for one cycle with done high, and last_body marks the
// final body of the step. Results cannot be held off by the receiver.
// In a step each pair needs a square root and three divisions on the shared
// divider, and each body two more divisions for its acceleration.
// A step on an empty table gives no results and busy stays low.
// Configuration is to be written through the APB port only while the block
// is idle; the user must keep to this, as the block does not enforce it.
// Reset empties the table and loads the default configuration; table
// entries themselves are not cleared.
module gravity_body_step
    import gbs_pkg::*;
#(
    parameter int MAX_BODIES = MAX_BODIES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic              operation,
    input  logic [POS_W-1:0]  pos_x,
    input  logic [POS_W-1:0]  pos_y,
    input  logic [VEL_W-1:0]  vel_x,
    input  logic [VEL_W-1:0]  vel_y,
    input  logic [MASS_W-1:0] body_mass,
    input  logic [DT_W-1:0]   time_step,
    output logic              done,
    output logic [IDX_W-1:0]  body_index,
    output logic [PIX_W-1:0]  pixel_x,
    output logic [PIX_W-1:0]  pixel_y,
    output logic              last_body
);

    localparam int IW = $clog2(MAX_BODIES);

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GRAV   = 2'd2;
    localparam logic [1:0] REG_MIND   = 2'd3;

    cfg_t          cfg_reg;
    cmd_t          cmd;
    stat_t         stat;
    logic [IW-1:0] addr;
    logic          cfg_wr;

    // Configuration registers; a transaction writes at the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width         <= LIM_W'(320);
            cfg_reg.screen_height        <= LIM_W'(180);
            cfg_reg.gravity_strength     <= G_W'(10000);
            cfg_reg.min_distance_squared <= MIND_W'(50);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_WIDTH:  cfg_reg.screen_width         <= pwdata[LIM_W-1:0];
                REG_HEIGHT: cfg_reg.screen_height        <= pwdata[LIM_W-1:0];
                REG_GRAV:   cfg_reg.gravity_strength     <= pwdata[G_W-1:0];
                REG_MIND:   cfg_reg.min_distance_squared <= pwdata[MIND_W-1:0];
                default:    cfg_reg.screen_width         <= cfg_reg.screen_width;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = 32'(cfg_reg.screen_width);
            REG_HEIGHT: prdata = 32'(cfg_reg.screen_height);
            REG_GRAV:   prdata = 32'(cfg_reg.gravity_strength);
            REG_MIND:   prdata = 32'(cfg_reg.min_distance_squared);
            default:    prdata = '0;
        endcase
    end

    gbs_ctrl #(
        .MAX_BODIES (MAX_BODIES),
        .IW         (IW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .operation  (operation),
        .stat       (stat),
        .cmd        (cmd),
        .addr       (addr),
        .busy       (busy),
        .done       (done),
        .body_index (body_index),
        .last_body  (last_body)
    );

    gbs_datapath #(
        .MAX_BODIES (MAX_BODIES),
        .IW         (IW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .addr      (addr),
        .cfg       (cfg_reg),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .body_mass (body_mass),
        .time_step (time_step),
        .stat      (stat),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y)
    );

`ifndef SYNTH
    // A result that is not the last of a step leaves the block still busy.
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last_body) |-> busy)
        else $error("step ended before its last result");

    // Two results are never delivered in adjacent cycles.
    a_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back to back results");

    // Every reported index lies inside the table.
    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(body_index) < MAX_BODIES))
        else $error("result index outside the table");

    // The final result of a step returns the block to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && last_body) |-> !busy)
        else $error("block still busy after the last result");
`endif

endmodule
